/* rtl/core/max_heap_priority_queue_macros.svh */
// Assertion helpers used by the checker file of the heap queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define MHPQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MHPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mhpq_pkg.sv */
package mhpq_pkg;

	localparam int CAPACITY  = 32;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = ADDR_W + 2;
	localparam int VALUE_W   = 32;
	localparam int ENTRIES_W = 6;

	// Entry count reported when the store is full, taken modulo the field range
	localparam logic [ENTRIES_W-1:0] ENTRIES_AT_FULL =
		ENTRIES_W'(CAPACITY % (1 << ENTRIES_W));

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Datapath commands issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_INS,
		DP_RM,
		DP_ST_FULL,
		DP_ST_EMPTY,
		DP_UP_READ,
		DP_UP_MOVE,
		DP_PLACE,
		DP_RM_ROOT,
		DP_RM_LAST,
		DP_DN_READL,
		DP_DN_LEFT,
		DP_DN_PICK,
		DP_DN_MOVE,
		DP_RESULT
	} dp_op_t;

	// Datapath flags seen by the controller
	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic at_root;
		logic parent_less;
		logic no_left;
		logic has_right;
		logic right_greater;
		logic stop_down;
	} dp_status_t;

endpackage

/* rtl/core/mhpq_if.sv */
interface mhpq_in_if;
	logic                   valid;
	logic                   ready;
	logic                   operation;
	mhpq_pkg::value_t       value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface mhpq_out_if;
	logic                                valid;
	logic                                ready;
	mhpq_pkg::value_t                    removed_value;
	mhpq_pkg::status_t                   status;
	logic [mhpq_pkg::ENTRIES_W-1:0]      entries;

	modport source (output valid, output removed_value, output status, output entries,
		input ready);
	modport sink (input valid, input removed_value, input status, input entries,
		output ready);
endinterface

/* rtl/core/mhpq_ram.sv */
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/mhpq_datapath.sv */
module mhpq_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mhpq_pkg::dp_op_t                cmd,
	input  logic                            in_operation,
	input  mhpq_pkg::value_t                in_value,
	output mhpq_pkg::dp_status_t            st,
	output mhpq_pkg::value_t                removed_value,
	output mhpq_pkg::status_t               status,
	output logic [mhpq_pkg::ENTRIES_W-1:0]  entries
);
	import mhpq_pkg::*;

	logic [CNT_W-1:0]             count_q;
	logic                         op_q;
	value_t                       item_q;
	value_t                       cval_q;
	value_t                       removed_q;
	status_t                      status_q;
	logic [ADDR_W-1:0]            pos_q;
	logic [ADDR_W-1:0]            child_q;
	value_t                       res_removed_q;
	status_t                      res_status_q;
	logic [ENTRIES_W-1:0]         res_entries_q;

	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [VALUE_W-1:0]           ram_wdata;
	logic                         ram_re;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [VALUE_W-1:0]           ram_rdata;
	value_t                       rd_val;

	logic [ADDR_W-1:0]            parent_idx;
	logic [IDX_W-1:0]             left_idx;
	logic [IDX_W-1:0]             right_idx;
	logic [IDX_W-1:0]             count_ext;
	logic [CNT_W+ENTRIES_W-1:0]   entries_ext;

	assign rd_val      = $signed(ram_rdata);
	assign parent_idx  = (pos_q - ADDR_W'(1)) >> 1;
	assign left_idx    = {1'b0, pos_q, 1'b1};
	assign right_idx   = left_idx + IDX_W'(1);
	assign count_ext   = IDX_W'(count_q);
	assign entries_ext = {{ENTRIES_W{1'b0}}, count_q};

	// Flags for the controller
	assign st.is_remove     = (op_q == OP_REMOVE);
	assign st.full          = (count_q >= CNT_W'(CAPACITY));
	assign st.empty         = (count_q == '0);
	assign st.at_root       = (pos_q == '0);
	assign st.parent_less   = (rd_val < item_q);
	assign st.no_left       = (left_idx >= count_ext);
	assign st.has_right     = (right_idx < count_ext);
	assign st.right_greater = (rd_val > cval_q);
	assign st.stop_down     = (item_q >= cval_q);

	// Drive the store ports from the current command
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = item_q;
		case (cmd)
			DP_RM: begin
				ram_re = 1'b1;
			end
			DP_UP_READ: begin
				ram_re    = 1'b1;
				ram_raddr = parent_idx;
			end
			DP_RM_ROOT: begin
				ram_re    = 1'b1;
				ram_raddr = count_q[ADDR_W-1:0];
			end
			DP_DN_READL: begin
				ram_re    = 1'b1;
				ram_raddr = left_idx[ADDR_W-1:0];
			end
			DP_DN_LEFT: begin
				ram_re    = 1'b1;
				ram_raddr = right_idx[ADDR_W-1:0];
			end
			DP_UP_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			DP_PLACE: begin
				ram_we = 1'b1;
			end
			DP_DN_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = cval_q;
			end
			default: begin
			end
		endcase
	end

	mhpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Track the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd == DP_INS) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd == DP_RM) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Advance the working registers and capture the result
	always_ff @(posedge clk) begin
		case (cmd)
			DP_LOAD: begin
				op_q   <= in_operation;
				item_q <= in_value;
			end
			DP_INS: begin
				pos_q     <= count_q[ADDR_W-1:0];
				status_q  <= ST_OK;
				removed_q <= '0;
			end
			DP_RM: begin
				status_q <= ST_OK;
			end
			DP_ST_FULL: begin
				status_q  <= ST_FULL;
				removed_q <= '0;
			end
			DP_ST_EMPTY: begin
				status_q  <= ST_EMPTY;
				removed_q <= '0;
			end
			DP_UP_MOVE: begin
				pos_q <= parent_idx;
			end
			DP_RM_ROOT: begin
				removed_q <= rd_val;
			end
			DP_RM_LAST: begin
				item_q <= rd_val;
				pos_q  <= '0;
			end
			DP_DN_LEFT: begin
				cval_q  <= rd_val;
				child_q <= left_idx[ADDR_W-1:0];
			end
			DP_DN_PICK: begin
				if (st.right_greater) begin
					cval_q  <= rd_val;
					child_q <= right_idx[ADDR_W-1:0];
				end
			end
			DP_DN_MOVE: begin
				pos_q <= child_q;
			end
			DP_RESULT: begin
				res_removed_q <= removed_q;
				res_status_q  <= status_q;
				res_entries_q <= entries_ext[ENTRIES_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign removed_value = res_removed_q;
	assign status        = res_status_q;
	assign entries       = res_entries_q;

endmodule

/* rtl/core/mhpq_ctrl.sv */
module mhpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  mhpq_pkg::dp_status_t  st,
	output mhpq_pkg::dp_op_t      cmd
);
	import mhpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_ROOT,
		S_RM_LAST,
		S_DN_L,
		S_DN_R,
		S_DN_PICK,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   result_load;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign result_load = (cmd == DP_RESULT);

	// Pick the next step and the datapath command
	always_comb begin
		state_d = state_q;
		cmd     = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd     = DP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!st.is_remove && st.full) begin
					cmd     = DP_ST_FULL;
					state_d = S_DONE;
				end else if (st.is_remove && st.empty) begin
					cmd     = DP_ST_EMPTY;
					state_d = S_DONE;
				end else if (!st.is_remove) begin
					cmd     = DP_INS;
					state_d = S_UP_RD;
				end else begin
					cmd     = DP_RM;
					state_d = S_RM_ROOT;
				end
			end
			S_UP_RD: begin
				if (st.at_root) begin
					cmd     = DP_PLACE;
					state_d = S_DONE;
				end else begin
					cmd     = DP_UP_READ;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (st.parent_less) begin
					cmd     = DP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					cmd     = DP_PLACE;
					state_d = S_DONE;
				end
			end
			S_RM_ROOT: begin
				cmd     = DP_RM_ROOT;
				state_d = S_RM_LAST;
			end
			S_RM_LAST: begin
				cmd     = DP_RM_LAST;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (st.no_left) begin
					cmd     = DP_PLACE;
					state_d = S_DONE;
				end else begin
					cmd     = DP_DN_READL;
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				cmd     = DP_DN_LEFT;
				state_d = st.has_right ? S_DN_PICK : S_DN_CMP;
			end
			S_DN_PICK: begin
				cmd     = DP_DN_PICK;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (st.stop_down) begin
					cmd     = DP_PLACE;
					state_d = S_DONE;
				end else begin
					cmd     = DP_DN_MOVE;
					state_d = S_DN_L;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd     = DP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/max_heap_priority_queue.sv */
// Binary max-heap priority queue of signed 32-bit values.
// The req channel takes one item: operation 0 inserts value, operation 1
// removes the largest entry. The rsp channel returns one item per request:
// removed_value (old root on a good remove, else 0), status (ok, full on
// insert, empty on remove) and entries, the count held afterwards.
// Items are processed one at a time. An insert climbs from the new leaf,
// one parent compare per level, until it reaches the root or stops below a
// parent that is not less. A remove takes the root, moves the last entry
// there and sinks it, reading the left child and, where present, the right
// child at each level, until it ends at a leaf or no child is larger.
// Rejected items go straight to the result. req takes the next item in the
// cycle after the result is loaded. The single read port of the heap store
// sets the pace: every parent or child compare waits on one registered read.
// The result sits in an output register, so req accepts the next item while
// rsp is stalled; a later item then waits at its end until the register frees.
// Reset clears the entry count and the handshake state; the store contents
// are not cleared and are read only after being written.
module max_heap_priority_queue (
	input logic       clk,
	input logic       arst_n,
	mhpq_in_if.sink   req,
	mhpq_out_if.source rsp
);
	import mhpq_pkg::*;

	dp_op_t     cmd;
	dp_status_t st;

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.st       (st),
		.cmd      (cmd)
	);

	mhpq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_operation (req.operation),
		.in_value     (req.value),
		.st           (st),
		.removed_value(rsp.removed_value),
		.status       (rsp.status),
		.entries      (rsp.entries)
	);

endmodule

/* rtl/core/mhpq_checker.sv */
`include "max_heap_priority_queue_macros.svh"

module mhpq_prop_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input mhpq_pkg::value_t                rsp_removed_value,
	input logic [1:0]                      rsp_status,
	input logic [mhpq_pkg::ENTRIES_W-1:0]  rsp_entries
);
	import mhpq_pkg::*;

	// A stalled result keeps its valid and its removed value
	`MHPQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_value), "rsp dropped or changed while stalled")

	// A full report means the store holds its capacity
	`MHPQ_ASSERT_IMPL(a_full_count, clk, arst_n, rsp_valid && rsp_status == ST_FULL, rsp_entries == ENTRIES_AT_FULL && rsp_removed_value == '0, "full status with wrong count")

	// An empty report means nothing is held and nothing returned
	`MHPQ_ASSERT_IMPL(a_empty_count, clk, arst_n, rsp_valid && rsp_status == ST_EMPTY, rsp_entries == '0 && rsp_removed_value == '0, "empty status with entries")

	// The count never exceeds the capacity
	`MHPQ_ASSERT_IMPL(a_count_range, clk, arst_n, rsp_valid && CAPACITY < 64, rsp_entries <= ENTRIES_AT_FULL, "entry count above capacity")

endmodule

bind max_heap_priority_queue mhpq_prop_checker u_mhpq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_removed_value(rsp.removed_value),
	.rsp_status       (rsp.status),
	.rsp_entries      (rsp.entries)
);
